// ----- sv/psh_pkg.sv -----
package psh_pkg;

	localparam int unsigned LANE_COUNT = 4;
	localparam int unsigned SIZE_W     = 31;

	typedef logic [7:0]              key_byte_t;
	typedef logic [SIZE_W-1:0]       size_t;
	typedef logic [LANE_COUNT-1:0][7:0] lanes_t;

	// Lane-count thresholds on the table size
	localparam size_t SIZE_ONE_LANE   = 31'd256;
	localparam size_t SIZE_TWO_LANES  = 31'd65536;
	localparam size_t SIZE_THREE_LANES = 31'd16777216;
	localparam size_t SIZE_RESET      = 31'd256;

	// Fixed Pearson permutation
	localparam logic [7:0] PERM_TABLE [0:255] = '{
		8'd1,   8'd87,  8'd49,  8'd12,  8'd176, 8'd178, 8'd102, 8'd166,
		8'd121, 8'd193, 8'd6,   8'd84,  8'd249, 8'd230, 8'd44,  8'd163,
		8'd14,  8'd197, 8'd213, 8'd181, 8'd161, 8'd85,  8'd218, 8'd80,
		8'd64,  8'd239, 8'd24,  8'd226, 8'd236, 8'd142, 8'd38,  8'd200,
		8'd110, 8'd177, 8'd104, 8'd103, 8'd141, 8'd253, 8'd255, 8'd50,
		8'd77,  8'd101, 8'd81,  8'd18,  8'd45,  8'd96,  8'd31,  8'd222,
		8'd25,  8'd107, 8'd190, 8'd70,  8'd86,  8'd237, 8'd240, 8'd34,
		8'd72,  8'd242, 8'd20,  8'd214, 8'd244, 8'd227, 8'd149, 8'd235,
		8'd97,  8'd234, 8'd57,  8'd22,  8'd60,  8'd250, 8'd82,  8'd175,
		8'd208, 8'd5,   8'd127, 8'd199, 8'd111, 8'd62,  8'd135, 8'd248,
		8'd174, 8'd169, 8'd211, 8'd58,  8'd66,  8'd154, 8'd106, 8'd195,
		8'd245, 8'd171, 8'd17,  8'd187, 8'd182, 8'd179, 8'd0,   8'd243,
		8'd132, 8'd56,  8'd148, 8'd75,  8'd128, 8'd133, 8'd158, 8'd100,
		8'd130, 8'd126, 8'd91,  8'd13,  8'd153, 8'd246, 8'd216, 8'd219,
		8'd119, 8'd68,  8'd223, 8'd78,  8'd83,  8'd88,  8'd201, 8'd99,
		8'd122, 8'd11,  8'd92,  8'd32,  8'd136, 8'd114, 8'd52,  8'd10,
		8'd138, 8'd30,  8'd48,  8'd183, 8'd156, 8'd35,  8'd61,  8'd26,
		8'd143, 8'd74,  8'd251, 8'd94,  8'd129, 8'd162, 8'd63,  8'd152,
		8'd170, 8'd7,   8'd115, 8'd167, 8'd241, 8'd206, 8'd3,   8'd150,
		8'd55,  8'd59,  8'd151, 8'd220, 8'd90,  8'd53,  8'd23,  8'd131,
		8'd125, 8'd173, 8'd15,  8'd238, 8'd79,  8'd95,  8'd89,  8'd16,
		8'd105, 8'd137, 8'd225, 8'd224, 8'd217, 8'd160, 8'd37,  8'd123,
		8'd118, 8'd73,  8'd2,   8'd157, 8'd46,  8'd116, 8'd9,   8'd145,
		8'd134, 8'd228, 8'd207, 8'd212, 8'd202, 8'd215, 8'd69,  8'd229,
		8'd27,  8'd188, 8'd67,  8'd124, 8'd168, 8'd252, 8'd42,  8'd4,
		8'd29,  8'd108, 8'd21,  8'd247, 8'd19,  8'd205, 8'd39,  8'd203,
		8'd233, 8'd40,  8'd186, 8'd147, 8'd198, 8'd192, 8'd155, 8'd33,
		8'd164, 8'd191, 8'd98,  8'd204, 8'd165, 8'd180, 8'd117, 8'd76,
		8'd140, 8'd36,  8'd210, 8'd172, 8'd41,  8'd54,  8'd159, 8'd8,
		8'd185, 8'd232, 8'd113, 8'd196, 8'd231, 8'd47,  8'd146, 8'd120,
		8'd51,  8'd65,  8'd28,  8'd144, 8'd254, 8'd221, 8'd93,  8'd189,
		8'd194, 8'd139, 8'd112, 8'd43,  8'd71,  8'd109, 8'd184, 8'd209
	};

endpackage

// ----- sv/psh_if.sv -----
interface psh_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;
	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

interface psh_hash_if;
	logic        valid;
	logic        ready;
	logic [30:0] hash_value;
	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

interface psh_cfg_if;
	logic        valid;
	logic        ready;
	logic [30:0] table_size;
	modport source (output valid, output table_size, input ready);
	modport sink (input valid, input table_size, output ready);
endinterface

// ----- sv/psh_lane_update.sv -----
module psh_lane_update (
	input  psh_pkg::key_byte_t key_byte,
	input  logic               first,
	input  psh_pkg::lanes_t    lanes,
	output psh_pkg::lanes_t    lanes_next
);
	import psh_pkg::*;

	// Seed each lane from byte plus lane index, or mix the byte into each lane
	always_comb begin
		for (int i = 0; i < LANE_COUNT; i++) begin
			if (first) begin
				lanes_next[i] = PERM_TABLE[key_byte + 8'(i)];
			end else begin
				lanes_next[i] = PERM_TABLE[lanes[i] ^ key_byte];
			end
		end
	end

endmodule

// ----- sv/pearson_string_hash_multiwidth.sv -----
// Pearson string hash, 8 to 31 bits wide.
// Channels: key (sink) takes one key byte per item; a zero byte ends the key.
// hash (source) gives one bucket index per finished key. cfg (sink) writes
// table_size; it is always ready and must only be written while idle.
// Width: table_size up to 2^8 uses lane 0, up to 2^16 lanes 1:0, up to 2^24
// lanes 2:0, else all four lanes; the result is masked with table_size - 1.
// Throughput: one byte per cycle unless a zero byte waits on a stalled hash.
// The byte is registered, then the four lane lookups into the permutation table
// run in the next cycle against the lane registers, so keys stream with no gaps.
// Result: a terminating zero byte is held in the byte register, and its hash is
// loaded into the hash register once that register is free.
// Stall: the hash register holds until taken. Nonzero bytes keep flowing while
// it waits; a zero byte waits in the byte register, which then blocks input.
// Reset: lanes clear, the next byte starts a key, table_size becomes 256, no
// items are in flight.
module pearson_string_hash_multiwidth (
	input logic   clk,
	input logic   arst_n,
	psh_key_if.sink    key,
	psh_hash_if.source hash,
	psh_cfg_if.sink    cfg
);
	import psh_pkg::*;

	key_byte_t byte_s1;
	logic      valid_s1;
	lanes_t    lanes_q;
	lanes_t    lanes_next;
	logic      first_q;
	size_t     size_q;
	size_t     hash_q;
	logic      out_valid_q;

	logic      zero_s1;
	logic      out_free;
	logic      go_s1;
	logic      key_fire;
	logic [31:0] lanes_cat;
	logic [31:0] width_mask;
	size_t     hash_next;

	assign zero_s1  = (byte_s1 == 8'd0);
	assign out_free = !out_valid_q || hash.ready;
	assign go_s1    = valid_s1 && (!zero_s1 || out_free);
	assign key.ready = !valid_s1 || go_s1;
	assign key_fire = key.valid && key.ready;
	assign cfg.ready = 1'b1;

	assign hash.valid      = out_valid_q;
	assign hash.hash_value = hash_q;

	// Register the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= key_fire || (valid_s1 && !go_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (key_fire) begin
			byte_s1 <= key.key_byte;
		end
	end

	psh_lane_update u_lane_update (
		.key_byte   (byte_s1),
		.first      (first_q),
		.lanes      (lanes_q),
		.lanes_next (lanes_next)
	);

	// Pick hash width from table size and mask with size minus one; an empty key hashes to zero
	always_comb begin
		lanes_cat = lanes_q;
		if (size_q <= SIZE_ONE_LANE) begin
			width_mask = 32'h0000_00ff;
		end else if (size_q <= SIZE_TWO_LANES) begin
			width_mask = 32'h0000_ffff;
		end else if (size_q <= SIZE_THREE_LANES) begin
			width_mask = 32'h00ff_ffff;
		end else begin
			width_mask = 32'hffff_ffff;
		end
		if (first_q) begin
			hash_next = '0;
		end else begin
			hash_next = lanes_cat[SIZE_W-1:0] & width_mask[SIZE_W-1:0] & (size_q - 31'd1);
		end
	end

	// Advance lanes on a byte; clear them and load the result on a zero byte; take table_size from cfg
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q     <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
			size_q      <= SIZE_RESET;
		end else begin
			if (cfg.valid) begin
				size_q <= cfg.table_size;
			end
			if (go_s1 && zero_s1) begin
				lanes_q     <= '0;
				first_q     <= 1'b1;
				out_valid_q <= 1'b1;
			end else begin
				if (go_s1) begin
					lanes_q <= lanes_next;
					first_q <= 1'b0;
				end
				if (hash.ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && zero_s1) begin
			hash_q <= hash_next;
		end
	end

endmodule

// ----- sv/psh_checker.sv -----
module psh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        key_valid,
	input logic        key_ready,
	input logic [7:0]  key_byte,
	input logic        hash_valid,
	input logic        hash_ready,
	input logic [30:0] hash_value,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [30:0] table_size
);
	logic [30:0] size_q;
	logic [1:0]  pending_q;
	logic        zero_fire;
	logic        hash_fire;

	assign zero_fire = key_valid && key_ready && (key_byte == 8'd0);
	assign hash_fire = hash_valid && hash_ready;

	// Track the table size and keys ended but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= 31'd256;
			pending_q <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= table_size;
			end
			pending_q <= pending_q + 2'(zero_fire) - 2'(hash_fire);
		end
	end

	a_hash_held: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash_ready |=> hash_valid)
		else $error("hash item dropped while stalled");

	a_hash_stable: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && !hash_ready |=> $stable(hash_value))
		else $error("hash value changed while stalled");

	a_hash_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && size_q != 31'd0 |-> hash_value < size_q)
		else $error("hash value beyond table size");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid |-> pending_q != 2'd0)
		else $error("hash item without a terminating byte");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many keys in flight");

endmodule

bind pearson_string_hash_multiwidth psh_checker u_psh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.key_valid  (key.valid),
	.key_ready  (key.ready),
	.key_byte   (key.key_byte),
	.hash_valid (hash.valid),
	.hash_ready (hash.ready),
	.hash_value (hash.hash_value),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.table_size (cfg.table_size)
);
